// File: src/utf8cyr_pkg.sv
// Shared types, constants and letter lookup for the UTF-8 Cyrillic transliterator.
package utf8cyr_pkg;

  // Depth of the queue between the front and back parts.
  localparam int unsigned QDEPTH = 2;
  localparam int unsigned QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

  localparam logic [7:0] LEAD_D0_BYTE = 8'hD0;
  localparam logic [7:0] LEAD_D1_BYTE = 8'hD1;

  // Pending lead byte of a two-byte Cyrillic sequence.
  typedef enum logic [1:0] {
    LEAD_NONE = 2'd0,
    LEAD_D0   = 2'd1,
    LEAD_D1   = 2'd2
  } lead_e;

  // Up to four ASCII characters; chars[0] is sent first.
  typedef struct packed {
    logic [3:0][6:0] chars;
    logic [2:0]      len;
  } spell_t;

  // Builds a spelling from up to four 8-bit character literals.
  function automatic spell_t mk_spell(logic [7:0] c0, logic [7:0] c1, logic [7:0] c2,
                                      logic [7:0] c3, logic [2:0] n);
    spell_t s;
    s.chars[0] = c0[6:0];
    s.chars[1] = c1[6:0];
    s.chars[2] = c2[6:0];
    s.chars[3] = c3[6:0];
    s.len      = n;
    return s;
  endfunction

  localparam spell_t SPELL_NONE = '0;

  // Latin spelling of the 32 basic Russian letters, A through YA.
  function automatic spell_t letter_lookup(logic [4:0] idx);
    spell_t s;
    case (idx)
      5'd0:    s = mk_spell("A", 8'h0, 8'h0, 8'h0, 3'd1);
      5'd1:    s = mk_spell("B", 8'h0, 8'h0, 8'h0, 3'd1);
      5'd2:    s = mk_spell("V", 8'h0, 8'h0, 8'h0, 3'd1);
      5'd3:    s = mk_spell("G", 8'h0, 8'h0, 8'h0, 3'd1);
      5'd4:    s = mk_spell("D", 8'h0, 8'h0, 8'h0, 3'd1);
      5'd5:    s = mk_spell("E", 8'h0, 8'h0, 8'h0, 3'd1);
      5'd6:    s = mk_spell("Z", "H", 8'h0, 8'h0, 3'd2);
      5'd7:    s = mk_spell("Z", 8'h0, 8'h0, 8'h0, 3'd1);
      5'd8:    s = mk_spell("I", 8'h0, 8'h0, 8'h0, 3'd1);
      5'd9:    s = mk_spell("Y", 8'h0, 8'h0, 8'h0, 3'd1);
      5'd10:   s = mk_spell("K", 8'h0, 8'h0, 8'h0, 3'd1);
      5'd11:   s = mk_spell("L", 8'h0, 8'h0, 8'h0, 3'd1);
      5'd12:   s = mk_spell("M", 8'h0, 8'h0, 8'h0, 3'd1);
      5'd13:   s = mk_spell("N", 8'h0, 8'h0, 8'h0, 3'd1);
      5'd14:   s = mk_spell("O", 8'h0, 8'h0, 8'h0, 3'd1);
      5'd15:   s = mk_spell("P", 8'h0, 8'h0, 8'h0, 3'd1);
      5'd16:   s = mk_spell("R", 8'h0, 8'h0, 8'h0, 3'd1);
      5'd17:   s = mk_spell("S", 8'h0, 8'h0, 8'h0, 3'd1);
      5'd18:   s = mk_spell("T", 8'h0, 8'h0, 8'h0, 3'd1);
      5'd19:   s = mk_spell("U", 8'h0, 8'h0, 8'h0, 3'd1);
      5'd20:   s = mk_spell("F", 8'h0, 8'h0, 8'h0, 3'd1);
      5'd21:   s = mk_spell("K", "H", 8'h0, 8'h0, 3'd2);
      5'd22:   s = mk_spell("T", "S", 8'h0, 8'h0, 3'd2);
      5'd23:   s = mk_spell("C", "H", 8'h0, 8'h0, 3'd2);
      5'd24:   s = mk_spell("S", "H", 8'h0, 8'h0, 3'd2);
      5'd25:   s = mk_spell("S", "H", "C", "H", 3'd4);
      5'd26:   s = SPELL_NONE;  // hard sign
      5'd27:   s = mk_spell("Y", 8'h0, 8'h0, 8'h0, 3'd1);
      5'd28:   s = SPELL_NONE;  // soft sign
      5'd29:   s = mk_spell("E", 8'h0, 8'h0, 8'h0, 3'd1);
      5'd30:   s = mk_spell("Y", "U", 8'h0, 8'h0, 3'd2);
      5'd31:   s = mk_spell("Y", "A", 8'h0, 8'h0, 3'd2);
      default: s = SPELL_NONE;
    endcase
    return s;
  endfunction

  // Spelling of the byte that follows a lead byte.
  function automatic spell_t map_second(lead_e lead, logic [7:0] b);
    spell_t s;
    s = SPELL_NONE;
    if (lead == LEAD_D0) begin
      if (b >= 8'h90 && b <= 8'hAF) begin
        s = letter_lookup({b[5], b[3:0]});
      end else if (b >= 8'hB0 && b <= 8'hBF) begin
        s = letter_lookup({1'b0, b[3:0]});
      end else if (b == 8'h84) begin
        s = mk_spell("Y", "E", 8'h0, 8'h0, 3'd2);
      end else if (b == 8'h86 || b == 8'h87) begin
        s = mk_spell("I", 8'h0, 8'h0, 8'h0, 3'd1);
      end
    end else begin
      if (b >= 8'h80 && b <= 8'h8F) begin
        s = letter_lookup({1'b1, b[3:0]});
      end else if (b == 8'h94) begin
        s = mk_spell("y", "e", 8'h0, 8'h0, 3'd2);
      end else if (b == 8'h96 || b == 8'h97) begin
        s = mk_spell("i", 8'h0, 8'h0, 8'h0, 3'd1);
      end
    end
    return s;
  endfunction

endpackage

// File: src/utf8cyr_front.sv
// Front part: accepts input bytes, tracks lead and skip state, and builds spellings.
module utf8cyr_front (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [7:0]            text_byte_i,
  input  logic                  end_of_string_i,
  input  logic                  q_full_i,
  output logic                  q_push_o,
  output utf8cyr_pkg::spell_t   q_data_o
);
  import utf8cyr_pkg::*;

  lead_e      lead_q, lead_d;
  logic [1:0] skip_q, skip_d;
  spell_t     spell;
  logic       accept;

  // A byte is taken whenever the queue has room.
  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i & ~q_full_i;

  // Classify the byte against the current state.
  always_comb begin
    lead_d = lead_q;
    skip_d = skip_q;
    spell  = SPELL_NONE;
    if (skip_q != 2'd0) begin
      skip_d = skip_q - 2'd1;
    end else if (lead_q != LEAD_NONE) begin
      spell  = map_second(lead_q, text_byte_i);
      lead_d = LEAD_NONE;
    end else if (!text_byte_i[7]) begin
      spell = mk_spell(text_byte_i, 8'h0, 8'h0, 8'h0, 3'd1);
    end else if (text_byte_i == LEAD_D0_BYTE) begin
      lead_d = LEAD_D0;
    end else if (text_byte_i == LEAD_D1_BYTE) begin
      lead_d = LEAD_D1;
    end else if (text_byte_i[7:4] == 4'hF) begin
      skip_d = 2'd3;
    end else if (text_byte_i[7:4] == 4'hE) begin
      skip_d = 2'd2;
    end else begin
      skip_d = 2'd1;
    end
    // The end of a string drops any unfinished sequence.
    if (end_of_string_i) begin
      lead_d = LEAD_NONE;
      skip_d = 2'd0;
    end
  end

  // Only bytes that produce characters go into the queue.
  assign q_push_o = accept & (spell.len != 3'd0);
  assign q_data_o = spell;

  // Sequence state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lead_q <= LEAD_NONE;
      skip_q <= 2'd0;
    end else if (accept) begin
      lead_q <= lead_d;
      skip_q <= skip_d;
    end
  end

endmodule

// File: src/utf8cyr_fifo.sv
// Short queue of spellings between the front and back parts.
module utf8cyr_fifo (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  utf8cyr_pkg::spell_t   push_data_i,
  output logic                  full_o,
  input  logic                  pop_i,
  output logic                  empty_o,
  output utf8cyr_pkg::spell_t   pop_data_o
);
  import utf8cyr_pkg::*;

  spell_t              mem_q [QDEPTH];
  logic [QPTR_W-1:0]   wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0]   count_q;
  logic                do_push, do_pop;

  assign full_o     = (count_q == QCNT_W'(QDEPTH));
  assign empty_o    = (count_q == '0);
  assign do_push    = push_i & ~full_o;
  assign do_pop     = pop_i & ~empty_o;
  assign pop_data_o = mem_q[rd_ptr_q];

  // Storage entries.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

// File: src/utf8cyr_back.sv
// Back part: sends spelling characters one per unstalled cycle from an output register.
module utf8cyr_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  q_empty_i,
  input  utf8cyr_pkg::spell_t   q_data_i,
  output logic                  q_pop_o,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [6:0]            out_char_o,
  output logic                  last_of_run_o
);
  import utf8cyr_pkg::*;

  logic            valid_q;
  logic [6:0]      char_q;
  logic [2:0][6:0] rest_q;
  logic [1:0]      left_q;
  logic            xfer;
  logic            free;

  assign xfer = valid_q & ~out_stall_i;
  // The output register frees up when it is empty or its last character leaves.
  assign free    = ~valid_q | (xfer & (left_q == 2'd0));
  assign q_pop_o = free & ~q_empty_i;

  assign out_valid_o   = valid_q;
  assign out_char_o    = char_q;
  assign last_of_run_o = (left_q == 2'd0);

  // Valid flag and count of characters still behind the one on show.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      left_q  <= 2'd0;
    end else if (q_pop_o) begin
      valid_q <= 1'b1;
      left_q  <= 2'(q_data_i.len - 3'd1);
    end else if (free) begin
      valid_q <= 1'b0;
    end else if (xfer) begin
      left_q <= left_q - 2'd1;
    end
  end

  // Character register and the shift line of those still to come.
  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      char_q <= q_data_i.chars[0];
      rest_q <= {q_data_i.chars[3], q_data_i.chars[2], q_data_i.chars[1]};
    end else if (xfer) begin
      char_q <= rest_q[0];
      rest_q <= {7'd0, rest_q[2], rest_q[1]};
    end
  end

endmodule

// File: src/utf8_cyrillic_transliterator.sv
// Top level of the UTF-8 Cyrillic to ASCII transliterator.
// Path: an accepted byte's spelling is written into the queue, then popped into the
// output register when that is free, where its first character is offered.
// Throughput: one byte per cycle while each yields at most one character and the
// output does not stall; a byte that yields several characters holds the
// one-character-per-cycle output register until its last character has left.
// Reset clears the lead and skip state, the queue and the output register.
module utf8_cyrillic_transliterator (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] text_byte_i,
  input  logic       end_of_string_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [6:0] out_char_o,
  output logic       last_of_run_o
);
  import utf8cyr_pkg::*;

  logic   q_push, q_full, q_pop, q_empty;
  spell_t q_wdata, q_rdata;

  // Byte classification and sequence state.
  utf8cyr_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .text_byte_i     (text_byte_i),
    .end_of_string_i (end_of_string_i),
    .q_full_i        (q_full),
    .q_push_o        (q_push),
    .q_data_o        (q_wdata)
  );

  // Decoupling queue.
  utf8cyr_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_data_i (q_wdata),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .empty_o     (q_empty),
    .pop_data_o  (q_rdata)
  );

  // Character output.
  utf8cyr_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_empty_i     (q_empty),
    .q_data_i      (q_rdata),
    .q_pop_o       (q_pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .out_char_o    (out_char_o),
    .last_of_run_o (last_of_run_o)
  );

endmodule

// File: bench/tb_utf8_cyrillic_transliterator.sv
// Self-checking testbench for the UTF-8 Cyrillic to ASCII transliterator.
module tb_utf8_cyrillic_transliterator;
  import utf8cyr_pkg::*;

  localparam int unsigned RANDOM_BYTES = 140;
  localparam int unsigned HOLD_CYCLES  = 150;
  localparam int unsigned HOLD_AFTER   = 80;
  localparam int unsigned DRAIN_CYCLES = 16;
  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned NUM_DIRECTED = 29;

  // One expected character on the output channel.
  typedef struct packed {
    logic [6:0] ch;
    logic       last;
  } out_char_t;

  // Scoreboard: tracks lead and skip state and holds the expected characters.
  class translit_scoreboard;
    lead_e       lead;
    logic [1:0]  skip_left;
    out_char_t   expected_chars[$];
    int unsigned errors;

    function new();
      lead      = LEAD_NONE;
      skip_left = 2'd0;
      errors    = 0;
    endfunction

    // Adds one character at the tail of the expected list.
    function void append_expected(out_char_t item);
      expected_chars = {expected_chars, item};
    endfunction

    // Latin spelling of the 32 basic letters, A through YA.
    function string latin_letter(int unsigned idx);
      case (idx)
        0: return "A";   1: return "B";   2: return "V";   3: return "G";
        4: return "D";   5: return "E";   6: return "ZH";  7: return "Z";
        8: return "I";   9: return "Y";   10: return "K";  11: return "L";
        12: return "M";  13: return "N";  14: return "O";  15: return "P";
        16: return "R";  17: return "S";  18: return "T";  19: return "U";
        20: return "F";  21: return "KH"; 22: return "TS"; 23: return "CH";
        24: return "SH"; 25: return "SHCH";
        27: return "Y";  29: return "E";  30: return "YU"; 31: return "YA";
        default: return "";
      endcase
    endfunction

    // Spelling of the byte that completes a two-byte sequence.
    function string second_spelling(lead_e ld, logic [7:0] b);
      if (ld == LEAD_D0) begin
        if (b >= 8'h90 && b <= 8'hAF) return latin_letter(32'(b) - 32'h90);
        if (b >= 8'hB0 && b <= 8'hBF) return latin_letter(32'(b) - 32'hB0);
        if (b == 8'h84) return "YE";
        if (b == 8'h86 || b == 8'h87) return "I";
        return "";
      end
      if (b >= 8'h80 && b <= 8'h8F) return latin_letter(32'(b) - 32'h80 + 32'd16);
      if (b == 8'h94) return "ye";
      if (b == 8'h96 || b == 8'h97) return "i";
      return "";
    endfunction

    // Predicts the characters caused by one accepted input byte.
    function void transliterate_byte(logic [7:0] b, logic eos);
      string     sp;
      out_char_t item;
      logic [7:0] c;
      sp = "";
      if (skip_left != 2'd0) begin
        skip_left = skip_left - 2'd1;
      end else if (lead != LEAD_NONE) begin
        sp   = second_spelling(lead, b);
        lead = LEAD_NONE;
      end else if (b < 8'h80) begin
        item.ch   = b[6:0];
        item.last = 1'b1;
        append_expected(item);
      end else if (b == LEAD_D0_BYTE) begin
        lead = LEAD_D0;
      end else if (b == LEAD_D1_BYTE) begin
        lead = LEAD_D1;
      end else if (b >= 8'hF0) begin
        skip_left = 2'd3;
      end else if (b >= 8'hE0) begin
        skip_left = 2'd2;
      end else begin
        skip_left = 2'd1;
      end
      for (int k = 0; k < sp.len(); k++) begin
        c         = sp[k];
        item.ch   = c[6:0];
        item.last = (k == sp.len() - 1);
        append_expected(item);
      end
      if (eos) begin
        lead      = LEAD_NONE;
        skip_left = 2'd0;
      end
    endfunction

    // Compares one output transfer with the oldest expected character.
    function void check_char(logic [6:0] c, logic last);
      out_char_t exp_item;
      if (expected_chars.size() == 0) begin
        $error("unexpected output transfer: out_char=%h last_of_run=%b", c, last);
        errors++;
        return;
      end
      exp_item = expected_chars.pop_front();
      if (c !== exp_item.ch) begin
        $error("out_char: expected %h, actual %h", exp_item.ch, c);
        errors++;
      end
      if (last !== exp_item.last) begin
        $error("last_of_run: expected %b, actual %b", exp_item.last, last);
        errors++;
      end
    endfunction
  endclass

  logic       clk_i;
  logic       rst_ni;
  logic       in_valid_i;
  logic       in_stall_o;
  logic [7:0] text_byte_i;
  logic       end_of_string_i;
  logic       out_valid_o;
  logic       out_stall_i;
  logic [6:0] out_char_o;
  logic       last_of_run_o;

  translit_scoreboard sb = new();
  int unsigned cycle_cnt  = 0;
  int unsigned sent_cnt   = 0;
  int unsigned burst_left = 0;
  bit          hold_req   = 1'b0;
  bit          hold_done  = 1'b0;

  utf8_cyrillic_transliterator DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .text_byte_i     (text_byte_i),
    .end_of_string_i (end_of_string_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .out_char_o      (out_char_o),
    .last_of_run_o   (last_of_run_o)
  );

  // Clock with a period of 10.
  initial clk_i = 1'b0;
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Run limit in case the block hangs.
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Every output transfer is checked against the scoreboard.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      sb.check_char(out_char_o, last_of_run_o);
    end
  end

  // Receiver: stall patterns that change over time, plus one long hold-off.
  initial begin : receiver
    int unsigned mode;
    int unsigned span;
    out_stall_i <= 1'b0;
    forever begin
      if (hold_req && !hold_done) begin
        out_stall_i <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_done = 1'b1;
      end else begin
        mode = $urandom_range(0, 3);
        span = $urandom_range(10, 60);
        for (int i = 0; i < span; i++) begin
          case (mode)
            0: out_stall_i <= 1'b0;
            1: out_stall_i <= ($urandom_range(0, 1) == 0);
            2: out_stall_i <= (i % 3 == 0);
            default: out_stall_i <= ($urandom_range(0, 4) != 0);
          endcase
          @(posedge clk_i);
        end
      end
    end
  end

  // Offers one byte, waits for its transfer, then ends the burst or continues.
  task automatic send_byte(input logic [7:0] b, input logic eos);
    in_valid_i      <= 1'b1;
    text_byte_i     <= b;
    end_of_string_i <= eos;
    do @(posedge clk_i); while (in_stall_o);
    sb.transliterate_byte(b, eos);
    sent_cnt++;
    if (sent_cnt == HOLD_AFTER) hold_req = 1'b1;
    if (burst_left == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
    end else begin
      burst_left--;
    end
  endtask

  // Random end-of-string flag, set on about one byte in sixteen.
  function automatic logic rand_eos();
    return ($urandom_range(0, 15) == 0);
  endfunction

  // Sends one random sequence: mostly well-formed UTF-8, some noise.
  task automatic send_random_sequence();
    int unsigned kind;
    logic [7:0]  second;
    kind = $urandom_range(0, 9);
    case (kind)
      0, 1, 2: send_byte(8'($urandom_range(0, 127)), rand_eos());
      3, 4, 5: begin
        second = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(8'h80, 8'hFF))
                                             : 8'($urandom_range(8'h90, 8'hBF));
        send_byte(LEAD_D0_BYTE, rand_eos());
        send_byte(second, rand_eos());
      end
      6: begin
        second = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                             : 8'($urandom_range(8'h80, 8'h9F));
        send_byte(LEAD_D1_BYTE, rand_eos());
        send_byte(second, rand_eos());
      end
      7: begin
        send_byte(8'($urandom_range(8'hE0, 8'hEF)), rand_eos());
        repeat (2) send_byte(8'($urandom_range(8'h80, 8'hBF)), rand_eos());
      end
      8: begin
        send_byte(8'($urandom_range(8'hF0, 8'hFF)), rand_eos());
        repeat (3) send_byte(8'($urandom_range(0, 255)), rand_eos());
      end
      default: send_byte(8'($urandom_range(0, 255)), rand_eos());
    endcase
  endtask

  // Main sequence: reset, directed bytes, random sequences, drain, verdict.
  initial begin : sender
    logic [8:0] directed [NUM_DIRECTED];
    directed = '{
      9'h000, 9'h07F,
      {1'b0, LEAD_D0_BYTE}, 9'h0A9, {1'b0, LEAD_D0_BYTE}, 9'h0AA,
      {1'b0, LEAD_D0_BYTE}, 9'h084, {1'b0, LEAD_D0_BYTE}, 9'h0C0,
      {1'b0, LEAD_D1_BYTE}, 9'h08F, {1'b0, LEAD_D1_BYTE}, 9'h094,
      {1'b0, LEAD_D1_BYTE}, 9'h041, {1'b0, LEAD_D0_BYTE}, {1'b0, LEAD_D1_BYTE},
      9'h0F0, 9'h011, 9'h022, 9'h033,
      9'h0E0, 9'h044, 9'h055,
      9'h080, 9'h066,
      {1'b1, LEAD_D0_BYTE}, 9'h1F7
    };
    rst_ni          <= 1'b0;
    in_valid_i      <= 1'b0;
    text_byte_i     <= 8'h00;
    end_of_string_i <= 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed bytes: extremes, special letters and cut-off sequences.
    for (int i = 0; i < NUM_DIRECTED; i++) begin
      send_byte(directed[i][7:0], directed[i][8]);
    end

    // Random sequences until enough bytes have been sent.
    while (sent_cnt < NUM_DIRECTED + RANDOM_BYTES) begin
      send_random_sequence();
    end
    in_valid_i <= 1'b0;

    // Wait for all expected characters, then let the output drain before the verdict.
    while (sb.expected_chars.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (sb.errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
